>>> rtl/core/rvcore_pkg.sv
// ----------------------------------------------------------------------------
// RV32I core package
// Shared request, response and control types, and the instruction encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package rvcore_pkg;

   typedef enum logic [1:0] {
      CMD_EXEC       = 2'd0,
      CMD_WRITE      = 2'd1,
      CMD_READ       = 2'd2,
      CMD_SOFT_RESET = 2'd3
   } op_type;

   typedef struct packed {
      op_type      cmd;
      logic [15:0] mem_addr;
      logic [31:0] mem_wdata;
   } req_type;

   typedef struct packed {
      logic [31:0] pc_out;
      logic        err_flag;
      logic [31:0] read_word;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic exec;
      logic mem;
      logic resp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mem_access;
   } dp_stat_type;

   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_ALUI   = 7'b0010011;
   localparam logic [6:0] OP_ALUR   = 7'b0110011;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;
   localparam logic [6:0] F7_ALT    = 7'b0100000;

endpackage

`default_nettype wire

>>> rtl/core/rvcore_ctrl.sv
// ----------------------------------------------------------------------------
// RV32I core controller
// Executes run fetch, decode, execute, memory (loads/stores only) and response; others go to response.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcore_ctrl
   import rvcore_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire req_type     req_payload,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DEC  = 5'b00010,
      S_EXE  = 5'b00100,
      S_MEM  = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_payload.cmd == CMD_EXEC) ? S_DEC : S_RESP;
            end
         end
         S_DEC: begin
            cmd.decode = 1'b1;
            state_in   = S_EXE;
         end
         S_EXE: begin
            cmd.exec = 1'b1;
            state_in = stat.mem_access ? S_MEM : S_RESP;
         end
         S_MEM: begin
            cmd.mem  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/rvcore_dpath.sv
// ----------------------------------------------------------------------------
// RV32I core datapath
// Word memory, register file, program counter, ALU and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcore_dpath
   import rvcore_pkg::*;
#(
   parameter int MEM_WORDS = 65536
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_payload,
   input  wire dp_cmd_type cmd,
   output dp_stat_type     stat,
   output rsp_type         rsp_payload
);

   localparam int AW = $clog2(MEM_WORDS);

   logic [31:0]   word_mem_ff [MEM_WORDS];
   logic [31:0]   mem_rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_idx;
   logic [31:0]   mem_wdata;

   logic [31:0]   rf_ff [32];
   logic [31:0]   rf_vld_ff;
   logic          rf_we;
   logic [31:0]   rf_wdata;

   logic [31:0]   pc_ff, pc_in;
   logic          err_ff, err_in;
   logic [31:0]   ir_ff, a_ff, b_ff;
   op_type        op_ff;
   rsp_type       rsp_ff;

   logic [6:0]    opc, f7;
   logic [2:0]    f3;
   logic [4:0]    rd;
   logic [31:0]   imm_i, imm_s, imm_b, imm_j, imm_u;
   logic [31:0]   alu_b, alu_res, daddr, pc_plus4, next_pc, wb, ld_word, ld_val;
   logic [31:0]   st_lane, st_word;
   logic [4:0]    sh, boff;
   logic          is_reg, alu_bad, take, bad, do_wb, is_load, is_store, ld_ok, st_ok;
   logic [AW+15:0] req_idx_wide;

   assign opc = ir_ff[6:0];
   assign rd  = ir_ff[11:7];
   assign f3  = ir_ff[14:12];
   assign f7  = ir_ff[31:25];

   assign imm_i = {{20{ir_ff[31]}}, ir_ff[31:20]};
   assign imm_s = {{20{ir_ff[31]}}, ir_ff[31:25], ir_ff[11:7]};
   assign imm_b = {{19{ir_ff[31]}}, ir_ff[31], ir_ff[7], ir_ff[30:25], ir_ff[11:8], 1'b0};
   assign imm_j = {{11{ir_ff[31]}}, ir_ff[31], ir_ff[19:12], ir_ff[20], ir_ff[30:21],
                   1'b0};
   assign imm_u = {ir_ff[31:12], 12'b0};

   assign pc_plus4 = pc_ff + 32'd4;
   assign is_load  = (opc == OP_LOAD);
   assign is_store = (opc == OP_STORE);
   assign ld_ok    = is_load && (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7);
   assign st_ok    = is_store && (f3 < 3'd3);
   assign stat.mem_access = ld_ok || st_ok;

   assign daddr = a_ff + (is_store ? imm_s : imm_i);
   assign boff  = {daddr[1:0], 3'b000};

   // ALU for register and immediate forms.
   assign is_reg = (opc == OP_ALUR);
   assign alu_b  = is_reg ? b_ff :
                   ((f3 == 3'd1) || (f3 == 3'd5)) ? {27'b0, ir_ff[24:20]} : imm_i;
   assign sh     = alu_b[4:0];

   always_comb begin
      alu_bad = is_reg && (f7 != 7'd0) &&
                !((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5)));
      alu_res = '0;
      case (f3)
         3'd0: alu_res = (is_reg && (f7 == F7_ALT)) ? a_ff - alu_b : a_ff + alu_b;
         3'd1: begin
            if (f7 != 7'd0) begin
               alu_bad = 1'b1;
            end
            alu_res = a_ff << sh;
         end
         3'd2: alu_res = {31'b0, ($signed(a_ff) < $signed(alu_b))};
         3'd3: alu_res = {31'b0, (a_ff < alu_b)};
         3'd4: alu_res = a_ff ^ alu_b;
         3'd5: begin
            if (f7 == 7'd0) begin
               alu_res = a_ff >> sh;
            end else if (f7 == F7_ALT) begin
               alu_res = $unsigned($signed(a_ff) >>> sh);
            end else begin
               alu_bad = 1'b1;
            end
         end
         3'd6: alu_res = a_ff | alu_b;
         default: alu_res = a_ff & alu_b;
      endcase
   end

   always_comb begin
      take = 1'b0;
      case (f3)
         3'd0: take = (a_ff == b_ff);
         3'd1: take = (a_ff != b_ff);
         3'd4: take = ($signed(a_ff) < $signed(b_ff));
         3'd5: take = !($signed(a_ff) < $signed(b_ff));
         3'd6: take = (a_ff < b_ff);
         3'd7: take = (a_ff >= b_ff);
         default: take = 1'b0;
      endcase
   end

   // Instruction decode and commit for the execute step.
   always_comb begin
      next_pc = pc_plus4;
      wb      = '0;
      do_wb   = 1'b0;
      bad     = 1'b0;
      unique case (opc)
         OP_LUI: begin
            wb    = imm_u;
            do_wb = 1'b1;
         end
         OP_AUIPC: begin
            wb    = imm_u + pc_ff;
            do_wb = 1'b1;
         end
         OP_JAL: begin
            wb      = pc_plus4;
            do_wb   = 1'b1;
            next_pc = pc_ff + imm_j;
         end
         OP_JALR: begin
            wb      = pc_plus4;
            do_wb   = 1'b1;
            next_pc = a_ff + imm_i;
         end
         OP_BRANCH: begin
            bad = (f3 == 3'd2) || (f3 == 3'd3);
            if (take) begin
               next_pc = pc_ff + imm_b;
            end
         end
         OP_LOAD:   bad = !ld_ok;
         OP_STORE:  bad = !st_ok;
         OP_ALUI, OP_ALUR: begin
            wb    = alu_res;
            do_wb = !alu_bad;
            bad   = alu_bad;
         end
         OP_SYSTEM: bad = (ir_ff[31:20] != 12'd0);
         default:   bad = 1'b1;
      endcase
      if (bad) begin
         next_pc = pc_plus4;
      end
   end

   // Load extraction and store merge.
   assign ld_word = mem_rdata_ff;
   always_comb begin
      ld_val = ld_word >> boff;
      case (f3)
         3'd0:    ld_val = {{24{ld_val[7]}}, ld_val[7:0]};
         3'd1:    ld_val = {{16{ld_val[15]}}, ld_val[15:0]};
         3'd2:    ld_val = ld_word;
         3'd4:    ld_val = {24'b0, ld_val[7:0]};
         default: ld_val = {16'b0, ld_val[15:0]};
      endcase
   end

   always_comb begin
      case (f3)
         3'd0:    st_lane = 32'h0000_00ff;
         3'd1:    st_lane = 32'h0000_ffff;
         default: st_lane = 32'hffff_ffff;
      endcase
      st_word = (ld_word & ~(st_lane << boff)) | ((b_ff & st_lane) << boff);
      if (f3 == 3'd2) begin
         st_word = b_ff;
      end
   end

   // Single memory port.
   assign req_idx_wide = {{AW{1'b0}}, req_payload.mem_addr};

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_idx   = daddr[AW+1:2];
      mem_wdata = st_word;
      if (cmd.accept) begin
         case (req_payload.cmd)
            CMD_EXEC: begin
               mem_re  = 1'b1;
               mem_idx = pc_ff[AW+1:2];
            end
            CMD_WRITE: begin
               mem_we    = 1'b1;
               mem_idx   = req_idx_wide[AW-1:0];
               mem_wdata = req_payload.mem_wdata;
            end
            CMD_READ: begin
               mem_re  = 1'b1;
               mem_idx = req_idx_wide[AW-1:0];
            end
            default: mem_re = 1'b0;
         endcase
      end else if (cmd.exec) begin
         mem_re = stat.mem_access;
      end else if (cmd.mem) begin
         mem_we = st_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem_ff[mem_idx] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= word_mem_ff[mem_idx];
      end
   end

   // Register file write-back.
   always_comb begin
      rf_we    = 1'b0;
      rf_wdata = wb;
      if (cmd.exec && !stat.mem_access) begin
         rf_we = do_wb && !bad;
      end else if (cmd.mem) begin
         rf_we    = ld_ok;
         rf_wdata = ld_val;
      end
      if (rd == 5'd0) begin
         rf_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[rd] <= rf_wdata;
      end
      if (cmd.decode) begin
         ir_ff <= mem_rdata_ff;
         a_ff  <= rf_vld_ff[mem_rdata_ff[19:15]] ? rf_ff[mem_rdata_ff[19:15]] : '0;
         b_ff  <= rf_vld_ff[mem_rdata_ff[24:20]] ? rf_ff[mem_rdata_ff[24:20]] : '0;
      end
      if (cmd.accept) begin
         op_ff <= req_payload.cmd;
      end
      if (cmd.resp_load) begin
         rsp_ff.pc_out    <= pc_ff;
         rsp_ff.err_flag  <= err_ff;
         rsp_ff.read_word <= (op_ff == CMD_READ) ? mem_rdata_ff : '0;
      end
   end

   // Program counter and sticky error.
   always_comb begin
      pc_in  = pc_ff;
      err_in = err_ff;
      if (cmd.accept && (req_payload.cmd == CMD_SOFT_RESET)) begin
         pc_in = '0;
      end else if (cmd.exec && !stat.mem_access) begin
         pc_in  = next_pc;
         err_in = err_ff | bad;
      end else if (cmd.mem) begin
         pc_in = pc_plus4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         err_ff    <= 1'b0;
         rf_vld_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         err_ff <= err_in;
         if (cmd.accept && (req_payload.cmd == CMD_SOFT_RESET)) begin
            rf_vld_ff <= '0;
         end else if (rf_we) begin
            rf_vld_ff[rd] <= 1'b1;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/rv32i_single_issue_core.sv
// Execute raises the response valid after the decode, execute and response states
// (loads and stores add a memory state). Memory write, memory read and soft reset
// go from acceptance straight to the response state. One request is in work at a time:
// the next is taken only in idle, and the response state waits while a response stalls.
// The single memory port serves fetch and data access in separate cycles.
// Reset clears pc, registers and error flag; memory contents are undefined until written.
// ----------------------------------------------------------------------------
// RV32I single-issue core
// Controller and datapath of a base-integer core with a local word memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_single_issue_core
   import rvcore_pkg::*;
#(
   parameter int MEM_WORDS = 65536
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rvcore_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   rvcore_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
